FILE: sv/bq_pkg.sv
// Shared types, constants and the microprogram of the biquad filter.
package bq_pkg;

	localparam int COEF_W             = 16;
	localparam int NUM_COEFS          = 5;
	localparam int DELAY_W            = 32;
	localparam int CFG_IDX_W          = 3;
	localparam int CFG_DATA_W         = 16;
	localparam int SAMPLE_WIDTH_DEF   = 16;
	localparam int COEF_FRAC_BITS_DEF = 14;
	localparam int STEP_W             = 4;

	// Register indexes double as coefficient selects for the multiplier.
	typedef enum logic [CFG_IDX_W-1:0] {
		COEF_B0 = 3'd0,
		COEF_B1 = 3'd1,
		COEF_B2 = 3'd2,
		COEF_A1 = 3'd3,
		COEF_A2 = 3'd4
	} coef_sel_t;

	typedef enum logic {
		OPND_X = 1'b0,
		OPND_Y = 1'b1
	} opnd_t;

	typedef enum logic [2:0] {
		ACC_HOLD      = 3'd0,
		ACC_LD_D1_RND = 3'd1,
		ACC_ADD       = 3'd2,
		ACC_SUB       = 3'd3,
		ACC_LD_D2_ADD = 3'd4,
		ACC_LD_NEG    = 3'd5
	} acc_op_t;

	typedef enum logic [1:0] {
		COND_NONE = 2'd0,
		COND_IN   = 2'd1,
		COND_OUT  = 2'd2
	} cond_t;

	typedef logic [STEP_W-1:0] step_t;

	localparam step_t ST_WAIT    = 4'd0;
	localparam step_t ST_MUL_B0  = 4'd1;
	localparam step_t ST_MUL_B1  = 4'd2;
	localparam step_t ST_OUT_Y   = 4'd3;
	localparam step_t ST_MUL_A1  = 4'd4;
	localparam step_t ST_MUL_A2  = 4'd5;
	localparam step_t ST_WR_D1   = 4'd6;
	localparam step_t ST_ADD_B2  = 4'd7;
	localparam step_t ST_WR_D2   = 4'd8;

	typedef struct packed {
		cond_t     cond;
		logic      last;
		logic      load_x;
		logic      mul_en;
		coef_sel_t coef;
		opnd_t     opnd;
		acc_op_t   acc_op;
		logic      y_we;
		logic      d1_we;
		logic      d2_we;
		logic      push;
	} ctrl_t;

	typedef struct packed {
		logic in_valid;
		logic out_free;
	} stat_t;

	function automatic ctrl_t ucode(step_t s);
		ctrl_t c;
		c = ctrl_t'('0);
		case (s)
			ST_WAIT: begin
				c.cond   = COND_IN;
				c.load_x = 1'b1;
			end
			ST_MUL_B0: begin
				c.mul_en = 1'b1;
				c.coef   = COEF_B0;
				c.opnd   = OPND_X;
				c.acc_op = ACC_LD_D1_RND;
			end
			ST_MUL_B1: begin
				c.mul_en = 1'b1;
				c.coef   = COEF_B1;
				c.opnd   = OPND_X;
				c.acc_op = ACC_ADD;
			end
			ST_OUT_Y: begin
				c.y_we   = 1'b1;
				c.acc_op = ACC_LD_D2_ADD;
			end
			ST_MUL_A1: begin
				c.mul_en = 1'b1;
				c.coef   = COEF_A1;
				c.opnd   = OPND_Y;
			end
			ST_MUL_A2: begin
				c.mul_en = 1'b1;
				c.coef   = COEF_A2;
				c.opnd   = OPND_Y;
				c.acc_op = ACC_SUB;
			end
			ST_WR_D1: begin
				c.d1_we  = 1'b1;
				c.acc_op = ACC_LD_NEG;
				c.mul_en = 1'b1;
				c.coef   = COEF_B2;
				c.opnd   = OPND_X;
			end
			ST_ADD_B2: begin
				c.acc_op = ACC_ADD;
			end
			ST_WR_D2: begin
				c.d2_we = 1'b1;
				c.push  = 1'b1;
				c.cond  = COND_OUT;
				c.last  = 1'b1;
			end
			default: begin
				c.last = 1'b1;
			end
		endcase
		return c;
	endfunction

endpackage

FILE: sv/bq_if.sv
// Valid/ready sample channels for the filter input and output.
interface bq_in_if #(
	parameter int W = bq_pkg::SAMPLE_WIDTH_DEF
);
	logic                valid;
	logic                ready;
	logic signed [W-1:0] sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink   (input valid, input sample_in, output ready);
endinterface

interface bq_out_if #(
	parameter int W = bq_pkg::SAMPLE_WIDTH_DEF
);
	logic                valid;
	logic                ready;
	logic signed [W-1:0] sample_out;

	modport source (output valid, output sample_out, input ready);
	modport sink   (input valid, input sample_out, output ready);
endinterface

FILE: sv/biquad_iir_filter.sv
// Biquad IIR filter, transposed direct form II, one shared multiplier under microcode.
// A request taken in the wait step runs the nine-step program through the single
// multiplier and single accumulator; the last step pushes the result, raising
// output valid, and stalls on a full output register; new requests wait till it ends.
// A finished result waits in the output register while the next request is taken.
// Reset clears coefficients, both delay states, the step counter and output valid.
module biquad_iir_filter #(
	parameter int SAMPLE_WIDTH   = bq_pkg::SAMPLE_WIDTH_DEF,
	parameter int COEF_FRAC_BITS = bq_pkg::COEF_FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bq_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bq_pkg::CFG_DATA_W-1:0] cfg_data,
	bq_in_if.sink                         in_ch,
	bq_out_if.source                      out_ch
);

	bq_pkg::ctrl_t ctrl;
	bq_pkg::stat_t stat;
	logic          adv;
	logic          out_free;

	assign stat.in_valid = in_ch.valid;
	assign stat.out_free = out_free;
	assign in_ch.ready   = (ctrl.cond == bq_pkg::COND_IN);

	bq_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl),
		.adv    (adv)
	);

	bq_datapath #(
		.SAMPLE_WIDTH   (SAMPLE_WIDTH),
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.adv        (adv),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.sample_in  (in_ch.sample_in),
		.out_ready  (out_ch.ready),
		.out_valid  (out_ch.valid),
		.sample_out (out_ch.sample_out),
		.out_free   (out_free)
	);

endmodule

FILE: sv/bq_seq.sv
// Step counter and microprogram decode for the biquad filter.
module bq_seq (
	input  logic          clk,
	input  logic          arst_n,
	input  bq_pkg::stat_t stat,
	output bq_pkg::ctrl_t ctrl,
	output logic          adv
);

	bq_pkg::step_t step_q;

	assign ctrl = bq_pkg::ucode(step_q);

	always_comb begin
		unique case (ctrl.cond)
			bq_pkg::COND_IN:  adv = stat.in_valid;
			bq_pkg::COND_OUT: adv = stat.out_free;
			default:          adv = 1'b1;
		endcase
	end

	// hold on a wait step until its condition is met
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= bq_pkg::ST_WAIT;
		end else if (adv) begin
			step_q <= ctrl.last ? bq_pkg::ST_WAIT : step_q + bq_pkg::step_t'(1);
		end
	end

endmodule

FILE: sv/bq_datapath.sv
// Shared multiplier, accumulator, delay states, coefficients and output register.
module bq_datapath #(
	parameter int SAMPLE_WIDTH   = bq_pkg::SAMPLE_WIDTH_DEF,
	parameter int COEF_FRAC_BITS = bq_pkg::COEF_FRAC_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  bq_pkg::ctrl_t                        ctrl,
	input  logic                                 adv,
	input  logic                                 cfg_we,
	input  logic [bq_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [bq_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  logic signed [SAMPLE_WIDTH-1:0]       sample_in,
	input  logic                                 out_ready,
	output logic                                 out_valid,
	output logic signed [SAMPLE_WIDTH-1:0]       sample_out,
	output logic                                 out_free
);

	localparam int PROD_W = bq_pkg::COEF_W + SAMPLE_WIDTH;
	localparam int ACC_W  = ((PROD_W > bq_pkg::DELAY_W) ? PROD_W : bq_pkg::DELAY_W) + 3;

	localparam logic signed [ACC_W-1:0] RND    = ACC_W'(1) << (COEF_FRAC_BITS - 1);
	localparam logic signed [ACC_W-1:0] SMAX_A = (ACC_W'(1) << (SAMPLE_WIDTH - 1)) - ACC_W'(1);
	localparam logic signed [ACC_W-1:0] SMIN_A = -SMAX_A - ACC_W'(1);
	localparam logic signed [bq_pkg::DELAY_W-1:0] DMAX = {1'b0, {(bq_pkg::DELAY_W-1){1'b1}}};
	localparam logic signed [bq_pkg::DELAY_W-1:0] DMIN = {1'b1, {(bq_pkg::DELAY_W-1){1'b0}}};
	localparam logic signed [ACC_W-1:0] DMAX_A = ACC_W'(DMAX);
	localparam logic signed [ACC_W-1:0] DMIN_A = ACC_W'(DMIN);
	localparam logic signed [SAMPLE_WIDTH-1:0] SMAX = SAMPLE_WIDTH'(SMAX_A);
	localparam logic signed [SAMPLE_WIDTH-1:0] SMIN = SAMPLE_WIDTH'(SMIN_A);

	logic signed [bq_pkg::COEF_W-1:0]  coef_q [bq_pkg::NUM_COEFS];
	logic signed [SAMPLE_WIDTH-1:0]    x_q;
	logic signed [SAMPLE_WIDTH-1:0]    y_q;
	logic signed [PROD_W-1:0]          p_q;
	logic signed [ACC_W-1:0]           acc_q;
	logic signed [bq_pkg::DELAY_W-1:0] d1_q;
	logic signed [bq_pkg::DELAY_W-1:0] d2_q;
	logic                              out_valid_q;
	logic signed [SAMPLE_WIDTH-1:0]    sample_out_q;

	logic signed [bq_pkg::COEF_W-1:0]  mul_a;
	logic signed [SAMPLE_WIDTH-1:0]    mul_b;
	logic signed [PROD_W-1:0]          prod;
	logic signed [ACC_W-1:0]           p_ext;
	logic signed [ACC_W-1:0]           acc_d;
	logic signed [ACC_W-1:0]           acc_sh;
	logic signed [SAMPLE_WIDTH-1:0]    y_d;
	logic signed [bq_pkg::DELAY_W-1:0] dsat;
	logic                              push;

	assign mul_a = coef_q[ctrl.coef];
	assign mul_b = (ctrl.opnd == bq_pkg::OPND_Y) ? y_q : x_q;
	assign prod  = mul_a * mul_b;
	assign p_ext = ACC_W'(p_q);

	always_comb begin
		case (ctrl.acc_op)
			bq_pkg::ACC_LD_D1_RND: acc_d = ACC_W'(d1_q) + RND;
			bq_pkg::ACC_ADD:       acc_d = acc_q + p_ext;
			bq_pkg::ACC_SUB:       acc_d = acc_q - p_ext;
			bq_pkg::ACC_LD_D2_ADD: acc_d = ACC_W'(d2_q) + p_ext;
			bq_pkg::ACC_LD_NEG:    acc_d = -p_ext;
			default:               acc_d = acc_q;
		endcase
	end

	// floor shift of the rounded sum, then clamp to the sample range
	assign acc_sh = acc_q >>> COEF_FRAC_BITS;

	always_comb begin
		if (acc_sh > SMAX_A) begin
			y_d = SMAX;
		end else if (acc_sh < SMIN_A) begin
			y_d = SMIN;
		end else begin
			y_d = acc_sh[SAMPLE_WIDTH-1:0];
		end
	end

	always_comb begin
		if (acc_q > DMAX_A) begin
			dsat = DMAX;
		end else if (acc_q < DMIN_A) begin
			dsat = DMIN;
		end else begin
			dsat = acc_q[bq_pkg::DELAY_W-1:0];
		end
	end

	assign out_free = !out_valid_q || out_ready;
	assign push     = ctrl.push && adv;

	always_ff @(posedge clk) begin
		if (ctrl.load_x && adv) begin
			x_q <= sample_in;
		end
		if (ctrl.mul_en) begin
			p_q <= prod;
		end
		acc_q <= acc_d;
		if (ctrl.y_we) begin
			y_q <= y_d;
		end
		if (push) begin
			sample_out_q <= y_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d1_q <= '0;
			d2_q <= '0;
			for (int i = 0; i < bq_pkg::NUM_COEFS; i++) begin
				coef_q[i] <= '0;
			end
		end else begin
			if (ctrl.d1_we) begin
				d1_q <= dsat;
			end
			if (ctrl.d2_we && adv) begin
				d2_q <= dsat;
			end
			// drop writes to indexes past the last coefficient
			if (cfg_we && (cfg_index < bq_pkg::CFG_IDX_W'(bq_pkg::NUM_COEFS))) begin
				coef_q[cfg_index] <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;

endmodule

FILE: sv/bq_checker.sv
// Port-level checks on the biquad filter, bound to the top level.
module bq_checker #(
	parameter int SAMPLE_WIDTH = bq_pkg::SAMPLE_WIDTH_DEF
) (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_ready,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic [SAMPLE_WIDTH-1:0] sample_out
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output request dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(sample_out))
		else $error("output sample changed while stalled");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready ##1 !in_ready ##1 !in_ready)
		else $error("new request taken while a sample is in work");

	a_push_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared without the program finishing");

endmodule

bind biquad_iir_filter bq_checker #(
	.SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_bq_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_ch.valid),
	.in_ready   (in_ch.ready),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.sample_out (out_ch.sample_out)
);
